>>> sv/itrd_pkg.sv
// Shared types, character codes and the digit-to-character map for the radix converter.
package itrd_pkg;

	localparam int VALUE_WIDTH_DEFAULT = 32;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W = 7;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam digit_t RADIX_MIN = 6'd2;
	localparam digit_t RADIX_MAX = 6'd36;
	localparam digit_t RADIX_RESET = 6'd10;
	localparam digit_t DIGIT_TEN = 6'd10;

	localparam char_t CHAR_ZERO = 7'h30;
	localparam char_t CHAR_SEVEN = 7'h37;
	localparam char_t CHAR_MINUS = 7'h2D;

	// Digits 0..9 map to '0'..'9', 10..35 to 'A'..'Z' ('7' + digit).
	function automatic char_t digit_char(input digit_t d);
		char_t ext;
		ext = {1'b0, d};
		if (d >= DIGIT_TEN) begin
			return CHAR_SEVEN + ext;
		end
		return CHAR_ZERO + ext;
	endfunction

endpackage

>>> sv/itrd_divider.sv
// Restoring shift-subtract divider, one quotient bit per clock, small runtime divisor.
module itrd_divider #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [WIDTH-1:0]    dividend,
	input  itrd_pkg::digit_t    divisor,
	output logic                done,
	output logic [WIDTH-1:0]    quotient,
	output itrd_pkg::digit_t    remainder
);
	import itrd_pkg::*;

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [CW-1:0] STEP_LAST = CW'(WIDTH - 1);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     step_q;
	logic [WIDTH-1:0]  quo_q;
	digit_t            rem_q;
	digit_t            div_q;

	logic [DIGIT_W:0]  trial;
	logic [DIGIT_W:0]  diff;
	logic              ge;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign ge = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_LAST) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the dividend out the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[WIDTH-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

>>> sv/itrd_digit_stack.sv
// Digit store: one write port, one registered read port.
module itrd_digit_stack #(
	parameter int DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(DEPTH)-1:0]          wr_addr,
	input  itrd_pkg::digit_t                  wr_data,
	input  logic [$clog2(DEPTH)-1:0]          rd_addr,
	output itrd_pkg::digit_t                  rd_data
);
	import itrd_pkg::*;

	digit_t mem_q [DEPTH];
	digit_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

>>> sv/integer_to_radix_digits.sv
// Top level: signed integer to ASCII text in a programmable radix, sequenced over one divider.
//
// Pulse start while busy is low to transfer one VALUE_WIDTH-bit two's complement value;
// the block raises busy and later emits its text one character per strobe cycle, an
// optional '-' first, then the digits most significant first, with last set on the final
// character. Zero gives "0" and the most negative value converts exactly. The receiver
// cannot stall: every strobe cycle is a transfer and must be taken. Each digit costs one
// pass of the shared bit-serial divider, so an item with more digits takes longer from
// start to its last strobe. Write radix_wdata with radix_we only while idle; codes
// below 2 act as 2 and codes above 36 act as 36. The radix resets to 10.
module integer_to_radix_digits #(
	parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [VALUE_WIDTH-1:0]  value,
	input  logic                    radix_we,
	input  itrd_pkg::digit_t        radix_wdata,
	output logic                    strobe,
	output itrd_pkg::char_t         ascii_char,
	output logic                    last
);
	import itrd_pkg::*;

	localparam int AW = $clog2(VALUE_WIDTH);
	localparam int NW = $clog2(VALUE_WIDTH + 1);
	localparam logic [NW-1:0] COUNT_FULL = NW'(VALUE_WIDTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIVIDE = 4'b0010,
		ST_PREP   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t                 state_q;
	digit_t                 radix_q;
	digit_t                 base_q;
	logic                   neg_q;
	logic [NW-1:0]          count_q;
	logic [AW-1:0]          ptr_q;
	logic                   strobe_q;
	char_t                  char_q;
	logic                   last_q;

	logic                   accept;
	logic                   value_neg;
	logic [VALUE_WIDTH-1:0] value_mag;
	digit_t                 base_clamped;
	logic                   div_load;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quot;
	digit_t                 div_rem;
	logic                   push;
	logic                   finish_div;
	logic [AW-1:0]          rd_addr;
	digit_t                 rd_digit;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// Magnitude as an unsigned quantity, so the most negative value needs no extra bit.
	assign value_neg = value[VALUE_WIDTH-1];
	assign value_mag = value_neg ? (~value + 1'b1) : value;

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base_clamped = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_clamped = RADIX_MAX;
		end else begin
			base_clamped = radix_q;
		end
	end

	// Each finished division pushes one digit; stop once the quotient runs out or the store is full.
	assign push = (state_q == ST_DIVIDE) && div_done;
	assign finish_div = push && ((div_quot == '0) || (count_q == COUNT_FULL));

	assign div_load = accept || (push && !finish_div);
	assign div_dividend = accept ? value_mag : div_quot;

	// Read the top digit in PREP, then walk down one entry per emit cycle.
	assign rd_addr = (state_q == ST_PREP) ? AW'(count_q - 1'b1) : (ptr_q - 1'b1);

	itrd_divider #(
		.WIDTH(VALUE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (div_dividend),
		.divisor  (accept ? base_clamped : base_q),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	itrd_digit_stack #(
		.DEPTH(VALUE_WIDTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (push),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(div_rem),
		.rd_addr(rd_addr),
		.rd_data(rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (push) begin
						count_q <= count_q + 1'b1;
						if (finish_div) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					// The sign goes out while the top digit is read.
					strobe_q <= neg_q;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: hold the item's sign and base, the read pointer, the character and its last flag.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value_neg;
			base_q <= base_clamped;
		end
		if (state_q == ST_PREP) begin
			ptr_q <= AW'(count_q - 1'b1);
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			ptr_q <= ptr_q - 1'b1;
			char_q <= digit_char(rd_digit);
			last_q <= (ptr_q == '0);
		end
	end

	assign strobe = strobe_q;
	assign ascii_char = char_q;
	assign last = last_q;

	// The next item's first character cannot directly follow a final character.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("strobe directly after a final character");

	// An accepted value keeps the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	// A divider result only shows up while digits are being produced.
	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide phase");

	// The digit count never exceeds the store depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(VALUE_WIDTH))
		else $error("digit count beyond store depth");

endmodule

>>> bench/integer_to_radix_digits_tb.sv
// Testbench for integer_to_radix_digits: directed table, then predictor-checked random values.
module integer_to_radix_digits_tb;
	import itrd_pkg::*;

	localparam int VW = VALUE_WIDTH_DEFAULT;
	// The worst correct run is far below this: 120 items, the slowest of them in radix 2,
	// plus the idle gaps between bursts.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Cycles to watch for stray strobes once nothing is expected any more.
	localparam int TAIL_CYCLES = 64;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int MAX_PRINTED = 30;

	// One character of expected text.
	typedef struct packed {
		char_t ch;
		logic  last;
	} text_char_t;

	typedef enum logic {
		ROW_SET_RADIX,
		ROW_CONVERT
	} row_kind_t;

	// A directed row: either a radix write or a value to convert. A non-empty text is the
	// expected string typed in; an empty one leaves the expectation to the predictor.
	typedef struct {
		row_kind_t     kind;
		digit_t        radix;
		logic [VW-1:0] value;
		string         text;
	} row_t;

	localparam int N_ROWS = 27;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [VW-1:0] value;
	logic          radix_we;
	digit_t        radix_wdata;
	logic          strobe;
	char_t         ascii_char;
	logic          last;

	text_char_t expected_chars [$];
	digit_t     radix_shadow;
	int         mismatch_count = 0;
	int         cycle_count = 0;

	row_t directed_rows [N_ROWS] = '{
		// Reset radix (ten): zero, a single digit, both signs, both extremes.
		'{ROW_CONVERT,   6'd0,  32'd0,         "0"},
		'{ROW_CONVERT,   6'd0,  32'd7,         "7"},
		'{ROW_CONVERT,   6'd0,  32'hFFFF_FFFF, "-1"},
		'{ROW_CONVERT,   6'd0,  32'h7FFF_FFFF, "2147483647"},
		'{ROW_CONVERT,   6'd0,  32'h8000_0000, "-2147483648"},
		'{ROW_CONVERT,   6'd0,  32'd1234567890, ""},
		// Top radix: the top digit 'Z', and the shortest strings.
		'{ROW_SET_RADIX, 6'd36, 32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'd35,        "Z"},
		'{ROW_CONVERT,   6'd0,  32'd36,        "10"},
		'{ROW_CONVERT,   6'd0,  32'h7FFF_FFFF, "ZIK0ZJ"},
		'{ROW_CONVERT,   6'd0,  32'h8000_0000, "-ZIK0ZK"},
		// Binary: the longest strings there are.
		'{ROW_SET_RADIX, 6'd2,  32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'd5,         "101"},
		'{ROW_CONVERT,   6'd0,  32'h8000_0000, ""},
		'{ROW_CONVERT,   6'd0,  32'h7FFF_FFFF, ""},
		// Codes below two act as two.
		'{ROW_SET_RADIX, 6'd0,  32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'd6,         "110"},
		'{ROW_SET_RADIX, 6'd1,  32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'hFFFF_FFFD, "-11"},
		// Codes above thirty-six act as thirty-six.
		'{ROW_SET_RADIX, 6'd63, 32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'd35,        "Z"},
		'{ROW_SET_RADIX, 6'd37, 32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'd10,        "A"},
		// Hex.
		'{ROW_SET_RADIX, 6'd16, 32'd0,         ""},
		'{ROW_CONVERT,   6'd0,  32'hDEAD_BEEF, ""},
		'{ROW_CONVERT,   6'd0,  32'd255,       "FF"},
		'{ROW_CONVERT,   6'd0,  32'h8000_0000, "-80000000"}
	};

	integer_to_radix_digits uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.strobe      (strobe),
		.ascii_char  (ascii_char),
		.last        (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the text of one value under the current radix and queue it, sign first,
	// then the digits most significant first. The magnitude is taken unsigned, so the
	// most negative value needs no special handling.
	function automatic void predict_text(input logic [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [VW-1:0] base;
		digit_t        digit_list [VW];
		int            n_digits;
		text_char_t    tc;
		base = VW'(radix_shadow);
		if (radix_shadow < RADIX_MIN) begin
			base = VW'(RADIX_MIN);
		end else if (radix_shadow > RADIX_MAX) begin
			base = VW'(RADIX_MAX);
		end
		mag = v[VW-1] ? (~v + 1'b1) : v;
		n_digits = 0;
		if (mag == '0) begin
			digit_list[0] = '0;
			n_digits = 1;
		end
		while (mag != '0) begin
			digit_list[n_digits] = digit_t'(mag % base);
			mag = mag / base;
			n_digits++;
		end
		if (v[VW-1]) begin
			tc.ch = CHAR_MINUS;
			tc.last = 1'b0;
			expected_chars.push_back(tc);
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			if (digit_list[i] < DIGIT_TEN) begin
				tc.ch = CHAR_ZERO + char_t'(digit_list[i]);
			end else begin
				tc.ch = CHAR_SEVEN + char_t'(digit_list[i]);
			end
			tc.last = (i == 0);
			expected_chars.push_back(tc);
		end
	endfunction

	// Queue a string typed into the table, last set on its final character.
	function automatic void queue_typed_text(input string s);
		text_char_t tc;
		for (int i = 0; i < s.len(); i++) begin
			tc.ch = char_t'(s[i]);
			tc.last = (i == s.len() - 1);
			expected_chars.push_back(tc);
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED) begin
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		end
		mismatch_count++;
	endtask

	// Hold start and value until the block takes the value, then queue its text. Start is
	// left high so a following call keeps the burst going without a dip.
	task automatic convert_value(input logic [VW-1:0] v, input string text);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (text.len() == 0) begin
			predict_text(v);
		end else begin
			queue_typed_text(text);
		end
	endtask

	// Drop start for a number of cycles; zero keeps the burst going.
	task automatic idle_sender(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop start and wait until every queued character has come and the block is idle.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_chars.size() != 0 || busy) begin
			@(posedge clk);
		end
	endtask

	// Write the radix only once the block has gone idle.
	task automatic write_radix(input digit_t r);
		drain_results();
		radix_we <= 1'b1;
		radix_wdata <= r;
		@(posedge clk);
		radix_we <= 1'b0;
		radix_shadow = r;
	endtask

	// Mostly full-width random values, with some small ones and the extremes mixed in.
	function automatic logic [VW-1:0] pick_value();
		logic [VW-1:0] v;
		case ($urandom_range(0, 9)) inside
			0: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = VW'(1);
					2: v = '1;
					3: v = {1'b0, {(VW-1){1'b1}}};
					default: v = {1'b1, {(VW-1){1'b0}}};
				endcase
			end
			[1:3]: v = VW'($urandom_range(0, 2000)) - VW'(1000);
			default: v = VW'($urandom);
		endcase
		return v;
	endfunction

	// Check every strobe against the oldest queued character. The strobe is sampled just
	// before the edge updates it, so the values seen are the ones the cycle carried.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ascii_char, last));
			end else begin
				want = expected_chars.pop_front();
				if (ascii_char !== want.ch) begin
					report_mismatch($sformatf("char 0x%02h, want 0x%02h", ascii_char, want.ch));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
				end
			end
		end
	end

	// Bound the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout: %0d chars still expected", expected_chars.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int     burst_left;
		digit_t phase_radix;
		radix_shadow = RADIX_RESET;
		arst_n <= 1'b0;
		start <= 1'b0;
		value <= '0;
		radix_we <= 1'b0;
		radix_wdata <= RADIX_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table back to back, radix writes in between.
		for (int r = 0; r < N_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_SET_RADIX) begin
				write_radix(directed_rows[r].radix);
			end else begin
				convert_value(directed_rows[r].value, directed_rows[r].text);
			end
		end

		// Random part: one radix per phase, values sent in bursts with random gaps. Long
		// gaps let the next start land on any point of the previous conversion.
		burst_left = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_radix = digit_t'($urandom_range(0, 63));
				1: phase_radix = RADIX_MIN;
				2: phase_radix = RADIX_MAX;
				3: phase_radix = digit_t'($urandom_range(3, 35));
				default: phase_radix = RADIX_RESET;
			endcase
			write_radix(phase_radix);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 2 && k == ITEMS_PER_PHASE / 2) begin
					// Hold off mid-phase until the block has emptied completely.
					drain_results();
				end
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						idle_sender($urandom_range(50, 400));
					end else begin
						idle_sender($urandom_range(0, 12));
					end
					burst_left = $urandom_range(1, 10);
				end
				convert_value(pick_value(), "");
				burst_left--;
			end
		end

		// Let the last text arrive, then watch a while for anything extra.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
